// ===== rtl/core/u8u32_pkg.sv =====
package u8u32_pkg;

   // End status codes reported on the result for the final byte.
   typedef enum logic [1:0] {
      END_CLEAN     = 2'd0,
      END_INVALID   = 2'd1,
      END_TRUNCATED = 2'd2,
      END_LIMIT     = 2'd3
   } end_status_type;

   localparam int CP_WIDTH    = 31;
   localparam int COUNT_WIDTH = 6;
   localparam int PEND_WIDTH  = 3;
   localparam int ONES_WIDTH  = 4;
   localparam int MAX_SEQ_LEN = 6;

   localparam logic [COUNT_WIDTH-1:0] MAX_CHARS_RESET = 6'd32;

   // Decoder state carried from one byte to the next.
   typedef struct packed {
      logic [PEND_WIDTH-1:0]  pending;
      logic [CP_WIDTH-1:0]    partial;
      logic [COUNT_WIDTH-1:0] count;
      logic                   halted;
      end_status_type         reason;
   } dec_state_type;

   // One result item.
   typedef struct packed {
      logic [CP_WIDTH-1:0]    code_point;
      logic                   has_char;
      logic                   end_of_buffer;
      end_status_type         end_status;
      logic [COUNT_WIDTH-1:0] chars_decoded;
   } dec_result_type;

   // Number of leading ones of a byte, 0 to 8.
   function automatic logic [ONES_WIDTH-1:0] lead_one_count(input logic [7:0] b);
      logic [ONES_WIDTH-1:0] n;
      logic                  run;
      n   = '0;
      run = 1'b1;
      for (int i = 7; i >= 0; i--) begin
         run = run & b[i];
         n   = n + {{(ONES_WIDTH-1){1'b0}}, run};
      end
      return n;
   endfunction

endpackage

// ===== rtl/core/utf8_to_utf32_decoder_core.sv =====
// Channel   Direction  Ports
// request   in         req_valid, req_ready, req_byte_in, req_last_byte
// response  out        rsp_valid, rsp_ready, rsp_code_point, rsp_has_char,
//                      rsp_end_of_buffer, rsp_end_status, rsp_chars_decoded
// csr       in         csr_wr_en, csr_wr_data (max_chars)
//
// One byte is taken per cycle while the response is not stalled; a result passes
// through the input register, then the decode logic into the result register.
// Reset sets max_chars to 32 and clears the decode state and both valids.
// A stalled response holds the input register; requests that complete no
// code point and are not final produce no response.
module utf8_to_utf32_decoder_core
   import u8u32_pkg::*;
#(
   parameter int OUTPUT_LIMIT = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_byte_in,
   input  logic                   req_last_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [CP_WIDTH-1:0]    rsp_code_point,
   output logic                   rsp_has_char,
   output logic                   rsp_end_of_buffer,
   output logic [1:0]             rsp_end_status,
   output logic [COUNT_WIDTH-1:0] rsp_chars_decoded,
   input  logic                   csr_wr_en,
   input  logic [COUNT_WIDTH-1:0] csr_wr_data
);

   localparam int LIMIT_MAX = (1 << COUNT_WIDTH) - 1;
   localparam logic [COUNT_WIDTH-1:0] LIMIT_CAP =
      COUNT_WIDTH'((OUTPUT_LIMIT > LIMIT_MAX) ? LIMIT_MAX : OUTPUT_LIMIT);

   logic [COUNT_WIDTH-1:0] max_chars_ff;
   logic                   in_valid_ff;
   logic [7:0]             in_byte_ff;
   logic                   in_last_ff;
   dec_state_type          state_ff;
   dec_state_type          state_in;
   logic                   out_valid_ff;
   dec_result_type         out_ff;
   dec_result_type         out_in;
   logic                   emit;
   logic                   out_free;
   logic                   consume;
   logic [COUNT_WIDTH-1:0] limit;

   // Handshake: the result register frees when empty or being drained.
   assign out_free  = !out_valid_ff || rsp_ready;
   assign consume   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || consume;
   assign limit     = (max_chars_ff < LIMIT_CAP) ? max_chars_ff : LIMIT_CAP;

   u8u32_decode u_decode (
      .byte_in    (in_byte_ff),
      .last_byte  (in_last_ff),
      .limit      (limit),
      .state      (state_ff),
      .state_next (state_in),
      .result     (out_in),
      .emit       (emit)
   );

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_chars_ff <= MAX_CHARS_RESET;
      end else if (csr_wr_en) begin
         max_chars_ff <= csr_wr_data;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         in_byte_ff <= req_byte_in;
         in_last_ff <= req_last_byte;
      end
   end

   // Decode state advances once per consumed byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{pending: '0, partial: '0, count: '0, halted: 1'b0,
                       reason: END_CLEAN};
      end else if (consume) begin
         state_ff <= state_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= consume && emit;
      end
      if (consume && emit) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_code_point    = out_ff.code_point;
   assign rsp_has_char      = out_ff.has_char;
   assign rsp_end_of_buffer = out_ff.end_of_buffer;
   assign rsp_end_status    = out_ff.end_status;
   assign rsp_chars_decoded = out_ff.chars_decoded;

endmodule

// ===== rtl/core/u8u32_decode.sv =====
module u8u32_decode
   import u8u32_pkg::*;
(
   input  logic [7:0]             byte_in,
   input  logic                   last_byte,
   input  logic [COUNT_WIDTH-1:0] limit,
   input  dec_state_type          state,
   output dec_state_type          state_next,
   output dec_result_type         result,
   output logic                   emit
);

   logic [ONES_WIDTH-1:0]  ones;
   logic [PEND_WIDTH-1:0]  pend_dec;
   logic [CP_WIDTH-1:0]    shifted;
   logic [7:0]             lead_mask;
   logic                   has;
   logic [CP_WIDTH-1:0]    cp;
   end_status_type         status;
   dec_state_type          nxt;

   assign ones      = lead_one_count(byte_in);
   assign pend_dec  = state.pending - 3'd1;
   assign shifted   = {state.partial[CP_WIDTH-7:0], byte_in[5:0]};
   assign lead_mask = 8'hFF >> (ones + 4'd1);

   // Per-byte decode: continuation merge, lead classification and halting.
   always_comb begin
      nxt    = state;
      has    = 1'b0;
      cp     = '0;
      status = END_CLEAN;
      if (state.halted) begin
         status = state.reason;
      end else if (state.pending != '0) begin
         nxt.partial = shifted;
         nxt.pending = pend_dec;
         if (pend_dec == '0) begin
            has = 1'b1;
            cp  = shifted;
         end else if (last_byte) begin
            nxt.halted = 1'b1;
            nxt.reason = END_TRUNCATED;
            status     = END_TRUNCATED;
         end
      end else if (state.count >= limit) begin
         nxt.halted = 1'b1;
         nxt.reason = END_LIMIT;
         status     = END_LIMIT;
      end else if (ones == 4'd1 || ones > ONES_WIDTH'(MAX_SEQ_LEN)) begin
         nxt.halted = 1'b1;
         nxt.reason = END_INVALID;
         status     = END_INVALID;
      end else if (ones == '0) begin
         has = 1'b1;
         cp  = {{(CP_WIDTH-7){1'b0}}, byte_in[6:0]};
      end else if (last_byte) begin
         nxt.halted = 1'b1;
         nxt.reason = END_TRUNCATED;
         status     = END_TRUNCATED;
      end else begin
         nxt.partial = {{(CP_WIDTH-8){1'b0}}, byte_in & lead_mask};
         nxt.pending = PEND_WIDTH'(ones - 4'd1);
      end

      // A completed code point bumps the count and clears the accumulator.
      if (has) begin
         nxt.count   = state.count + 6'd1;
         nxt.partial = '0;
      end

      result.code_point    = cp;
      result.has_char      = has;
      result.end_of_buffer = last_byte;
      result.end_status    = last_byte ? status : END_CLEAN;
      result.chars_decoded = nxt.count;

      // The final byte returns all state to zero for the next buffer.
      if (last_byte) begin
         nxt = '{pending: '0, partial: '0, count: '0, halted: 1'b0, reason: END_CLEAN};
      end
      state_next = nxt;
      emit       = has | last_byte;
   end

endmodule

// ===== dv/utf8_to_utf32_decoder_core_test.sv =====
`timescale 1ns / 100ps

module utf8_to_utf32_decoder_core_test;
   import u8u32_pkg::*;

   localparam int CHAR_LIMIT  = 32;
   localparam int HOLD_CYCLES = 150;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_BYTES = 80;
   localparam int HOLD_PHASE  = 4;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } utf8_byte_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [7:0]             req_byte_in = 8'h00;
   logic                   req_last_byte = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [CP_WIDTH-1:0]    rsp_code_point;
   logic                   rsp_has_char;
   logic                   rsp_end_of_buffer;
   logic [1:0]             rsp_end_status;
   logic [COUNT_WIDTH-1:0] rsp_chars_decoded;
   logic                   csr_wr_en = 1'b0;
   logic [COUNT_WIDTH-1:0] csr_wr_data = '0;

   // Bytes waiting to be offered, and decoded results waiting to arrive.
   utf8_byte_type  pending_bytes[$];
   dec_result_type expected_chars[$];
   int             bytes_queued = 0;
   int             bytes_taken = 0;
   int             mismatches = 0;
   int             cycle_count = 0;
   logic           req_taken = 1'b0;
   int             send_gap = 0;
   int             ready_gap = 0;
   int             hold_left = 0;
   bit             hold_fired = 1'b0;
   bit             stall_request = 1'b0;
   bit             sender_calm = 1'b0;
   bit             receiver_calm = 1'b0;

   // Shadow copy of the decoder state and its limit register.
   logic [COUNT_WIDTH-1:0] cfg_max_chars = MAX_CHARS_RESET;
   logic [PEND_WIDTH-1:0]  dec_pending = '0;
   logic [CP_WIDTH-1:0]    dec_partial = '0;
   logic [COUNT_WIDTH-1:0] dec_count = '0;
   logic                   dec_halted = 1'b0;
   end_status_type         dec_reason = END_CLEAN;

   utf8_to_utf32_decoder_core #(
      .OUTPUT_LIMIT(CHAR_LIMIT)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_byte_in(req_byte_in),
      .req_last_byte(req_last_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_code_point(rsp_code_point),
      .rsp_has_char(rsp_has_char),
      .rsp_end_of_buffer(rsp_end_of_buffer),
      .rsp_end_status(rsp_end_status),
      .rsp_chars_decoded(rsp_chars_decoded),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #1 clock = ~clock;

   // Mostly short gaps, now and then a long one; none at all in a calm stretch.
   function automatic int pick_gap(bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55)
         return 0;
      else if (r < 93)
         return $urandom_range(1, 3);
      else
         return $urandom_range(15, 40);
   endfunction

   // Halts decoding for the rest of the buffer.
   function automatic void stop_buffer(end_status_type why, output end_status_type status);
      dec_halted = 1'b1;
      dec_reason = why;
      status     = why;
   endfunction

   // Advances the shadow decoder by one byte and forms the result it causes.
   function automatic void decode_byte(input logic [7:0] b, input logic last,
                                       output logic emit, output dec_result_type res);
      logic [3:0]          ones;
      int                  lim;
      logic                has;
      logic [CP_WIDTH-1:0] cp;
      end_status_type      status;
      has    = 1'b0;
      cp     = '0;
      status = END_CLEAN;
      if (dec_halted) begin
         status = dec_reason;
      end else if (dec_pending != 0) begin
         // Continuation byte: only its low six bits count.
         dec_partial = {dec_partial[CP_WIDTH-7:0], b[5:0]};
         dec_pending = dec_pending - 1'b1;
         if (dec_pending == 0) begin
            has = 1'b1;
            cp  = dec_partial;
         end else if (last) begin
            stop_buffer(END_TRUNCATED, status);
         end
      end else begin
         lim = (int'(cfg_max_chars) < CHAR_LIMIT) ? int'(cfg_max_chars) : CHAR_LIMIT;
         ones = '0;
         for (int i = 7; i >= 0; i--)
            if (b[i] && ones == 4'(7 - i))
               ones = ones + 1'b1;
         if (int'(dec_count) >= lim) begin
            stop_buffer(END_LIMIT, status);
         end else if (ones == 1 || ones > MAX_SEQ_LEN) begin
            stop_buffer(END_INVALID, status);
         end else if (ones == 0) begin
            has = 1'b1;
            cp  = CP_WIDTH'(b[6:0]);
         end else if (last) begin
            stop_buffer(END_TRUNCATED, status);
         end else begin
            dec_partial = CP_WIDTH'(b & (8'hFF >> (ones + 1)));
            dec_pending = PEND_WIDTH'(ones - 1);
         end
      end
      if (has) begin
         dec_count   = dec_count + 1'b1;
         dec_partial = '0;
      end
      emit              = has || last;
      res.code_point    = cp;
      res.has_char      = has;
      res.end_of_buffer = last;
      res.end_status    = last ? status : END_CLEAN;
      res.chars_decoded = dec_count;
      if (last) begin
         dec_pending = '0;
         dec_partial = '0;
         dec_count   = '0;
         dec_halted  = 1'b0;
         dec_reason  = END_CLEAN;
      end
   endfunction

   function automatic void check_field(string name, longint unsigned want,
                                       longint unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0h got %0h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // Request driver: holds each request until it is taken.
   always @(negedge clock) begin
      utf8_byte_type staged;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (send_gap > 0) begin
            req_valid <= 1'b0;
            send_gap  <= send_gap - 1;
         end else if (pending_bytes.size() != 0) begin
            staged = pending_bytes.pop_front();
            req_valid     <= 1'b1;
            req_byte_in   <= staged.data;
            req_last_byte <= staged.last;
            send_gap      <= pick_gap(sender_calm);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Each accepted request updates the shadow decoder.
   always @(posedge clock) begin
      logic           emit;
      dec_result_type res;
      req_taken <= !reset && req_valid && req_ready;
      if (!reset && req_valid && req_ready) begin
         bytes_taken++;
         decode_byte(req_byte_in, req_last_byte, emit, res);
         if (emit)
            expected_chars.push_back(res);
      end
   end

   // Response ready: random gaps, plus one long hold-off when requested.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (stall_request && !hold_fired) begin
         rsp_ready  <= 1'b0;
         hold_left  <= HOLD_CYCLES;
         hold_fired <= 1'b1;
      end else if (ready_gap > 0) begin
         rsp_ready <= 1'b0;
         ready_gap <= ready_gap - 1;
      end else begin
         rsp_ready <= 1'b1;
         ready_gap <= pick_gap(receiver_calm);
      end
   end

   // Response monitor: compares every result against the oldest prediction.
   always @(posedge clock) begin
      dec_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_chars.size() == 0) begin
            $display("%0t: unexpected result code_point %0h status %0d", $time,
                     rsp_code_point, rsp_end_status);
            mismatches++;
         end else begin
            want = expected_chars.pop_front();
            check_field("code_point", want.code_point, rsp_code_point);
            check_field("has_char", want.has_char, rsp_has_char);
            check_field("end_of_buffer", want.end_of_buffer, rsp_end_of_buffer);
            check_field("end_status", want.end_status, rsp_end_status);
            check_field("chars_decoded", want.chars_decoded, rsp_chars_decoded);
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: run did not complete", $time);
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic push_byte(logic [7:0] b, logic last);
      pending_bytes.push_back('{data: b, last: last});
      bytes_queued++;
   endtask

   task automatic push_buffer(logic [7:0] bytes[$]);
      foreach (bytes[i])
         push_byte(bytes[i], i == bytes.size() - 1);
   endtask

   // Waits until every request is taken and every result has arrived.
   task automatic wait_idle();
      while (bytes_taken != bytes_queued || expected_chars.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_max_chars(logic [COUNT_WIDTH-1:0] value);
      @(negedge clock);
      csr_wr_en     <= 1'b1;
      csr_wr_data   <= value;
      cfg_max_chars = value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Builds one random buffer: mostly well-formed sequences, some noise,
   // and now and then a final sequence cut short.
   task automatic queue_random_buffer(int nchars, bit cut);
      logic [7:0] seq[$];
      int         len;
      int         r;
      len = 1;
      for (int c = 0; c < nchars; c++) begin
         r = $urandom_range(0, 99);
         if (r < 8) begin
            seq.push_back(8'($urandom));
            len = 1;
         end else begin
            len = ($urandom_range(0, 99) < 40) ? 1 : $urandom_range(2, MAX_SEQ_LEN);
            if (len == 1) begin
               seq.push_back({1'b0, 7'($urandom)});
            end else begin
               seq.push_back((8'hFF << (8 - len)) | (8'($urandom) & (8'hFF >> (len + 1))));
               for (int k = 1; k < len; k++)
                  seq.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                           : {2'b10, 6'($urandom)});
            end
         end
      end
      if (cut && len > 1)
         repeat ($urandom_range(1, len - 1)) void'(seq.pop_back());
      push_buffer(seq);
   endtask

   initial begin
      int cfg_values[$];
      int phase_start;
      int r;
      cfg_values = '{63, 1, 0, 5, 32, 2, 31, -1};
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed buffers at the reset limit.
      write_max_chars(MAX_CHARS_RESET);
      push_buffer('{8'h00, 8'h7F, 8'hC3, 8'hA9,
                    8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'h41});
      // Sequence cut off by the end of the buffer.
      push_buffer('{8'hE2, 8'h82});
      // Lone continuation byte as a lead, then halted bytes.
      push_buffer('{8'h80, 8'h41, 8'h42});
      // Eight and seven leading ones, and a multi-byte lead as the final byte.
      push_buffer('{8'hFF});
      push_buffer('{8'hFE});
      push_buffer('{8'hF0});
      wait_idle();

      // Limit of one: a buffer over the limit, then one ending exactly at it.
      write_max_chars(6'd1);
      push_buffer('{8'h41, 8'h42});
      push_buffer('{8'h41});
      wait_idle();

      // Zero limit stops at the first lead byte.
      write_max_chars(6'd0);
      push_buffer('{8'h41});
      wait_idle();

      // Random phases, each at its own limit setting.
      foreach (cfg_values[p]) begin
         write_max_chars(cfg_values[p] < 0 ? COUNT_WIDTH'($urandom_range(0, 63))
                                           : COUNT_WIDTH'(cfg_values[p]));
         sender_calm   = ($urandom_range(0, 3) == 0);
         receiver_calm = ($urandom_range(0, 3) == 0);
         phase_start   = bytes_queued;
         while (bytes_queued - phase_start < PHASE_BYTES) begin
            r = $urandom_range(0, 99);
            if (r < 5)
               queue_random_buffer($urandom_range(30, 45), $urandom_range(0, 9) == 0);
            else if (r < 20)
               queue_random_buffer($urandom_range(9, 20), $urandom_range(0, 9) == 0);
            else
               queue_random_buffer($urandom_range(1, 8), $urandom_range(0, 9) == 0);
         end
         if (p == HOLD_PHASE) begin
            sender_calm   = 1'b1;
            stall_request = 1'b1;
         end
         wait_idle();
      end

      repeat (10) @(posedge clock);
      if (mismatches == 0 && expected_chars.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
